// ----- hdl/fixed_point_alu_top_assert.svh -----
// assertion macros for the fixed-point alu
`ifndef FIXED_POINT_ALU_TOP_ASSERT_SVH
`define FIXED_POINT_ALU_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define FPA_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be true outside reset
`define FPA_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define FPA_ASSERT(name, clk, rst, prop, msg)
`define FPA_NEVER(name, clk, rst, cond, msg)
`endif
`endif

// ----- hdl/fpa_pkg.sv -----
// shared types and constants of the fixed-point alu
`timescale 1ns / 1ps
package fpa_pkg;
   localparam int FRAC_BITS  = 8;
   localparam int WORD_BITS  = 32;
   localparam int PORT_BITS  = 32;
   localparam int NUM_BITS   = WORD_BITS + FRAC_BITS;
   localparam int PROD_BITS  = 2 * WORD_BITS;
   localparam int CLAMP_BITS = PROD_BITS + 1;
   localparam int DIV_STEPS  = NUM_BITS;
   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

   localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [CLAMP_BITS-1:0] LIM_POS  = CLAMP_BITS'(WORD_MAX);
   localparam logic [CLAMP_BITS-1:0] LIM_NEG  = LIM_POS + CLAMP_BITS'(1);
   localparam logic [CLAMP_BITS-1:0] MUL_HALF = CLAMP_BITS'(1) << (FRAC_BITS - 1);

   typedef enum logic [3:0] {
      FUNC_ADD = 4'd0,
      FUNC_SUB = 4'd1,
      FUNC_MUL = 4'd2,
      FUNC_DIV = 4'd3,
      FUNC_MIN = 4'd4,
      FUNC_MAX = 4'd5,
      FUNC_INC = 4'd6,
      FUNC_DEC = 4'd7,
      FUNC_INT = 4'd8
   } func_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIV0 = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_DIRECT = 2'd0,
      KIND_MUL    = 2'd1,
      KIND_DIV    = 2'd2
   } kind_type;

   // classified request handed from front to back
   typedef struct packed {
      kind_type                      kind;
      logic                          neg;
      logic [WORD_BITS-1:0]          mag_a;
      logic [WORD_BITS-1:0]          mag_b;
      logic signed [WORD_BITS-1:0]   result;
      status_type                    status;
      logic                          a_less;
      logic                          a_equal;
      logic                          a_greater;
   } job_type;
endpackage

// ----- hdl/fpa_front.sv -----
// front end: decodes a request and computes the operations that need no multiplier or divider
`timescale 1ns / 1ps
module fpa_front import fpa_pkg::*; (
   input  logic [3:0]              req_func,
   input  logic signed [PORT_BITS-1:0] req_operand_a,
   input  logic signed [PORT_BITS-1:0] req_operand_b,
   output job_type                 job
);
   logic signed [WORD_BITS-1:0] a;
   logic signed [WORD_BITS-1:0] b;
   logic signed [WORD_BITS:0]   sum;
   logic signed [WORD_BITS:0]   diff;
   logic signed [WORD_BITS:0]   inc;
   logic signed [WORD_BITS:0]   dec;

   assign a = req_operand_a[WORD_BITS-1:0];
   assign b = req_operand_b[WORD_BITS-1:0];

   // wide sums, overflow shows as differing top bits
   assign sum  = (WORD_BITS+1)'(a) + (WORD_BITS+1)'(b);
   assign diff = (WORD_BITS+1)'(a) - (WORD_BITS+1)'(b);
   assign inc  = (WORD_BITS+1)'(a) + (WORD_BITS+1)'(1);
   assign dec  = (WORD_BITS+1)'(a) - (WORD_BITS+1)'(1);

   function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [WORD_BITS:0] v);
      if (v[WORD_BITS] != v[WORD_BITS-1]) begin
         return v[WORD_BITS] ? WORD_MIN : WORD_MAX;
      end
      return v[WORD_BITS-1:0];
   endfunction

   function automatic logic is_ovf(input logic signed [WORD_BITS:0] v);
      return v[WORD_BITS] != v[WORD_BITS-1];
   endfunction

   // classify and compute
   always_comb begin
      job           = '0;
      job.kind      = KIND_DIRECT;
      job.status    = ST_OK;
      job.a_less    = a < b;
      job.a_equal   = a == b;
      job.a_greater = a > b;
      job.neg       = a[WORD_BITS-1] ^ b[WORD_BITS-1];
      job.mag_a     = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
      job.mag_b     = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);
      case (req_func)
         FUNC_ADD: begin
            job.result = sat_word(sum);
            job.status = is_ovf(sum) ? ST_SAT : ST_OK;
         end
         FUNC_SUB: begin
            job.result = sat_word(diff);
            job.status = is_ovf(diff) ? ST_SAT : ST_OK;
         end
         FUNC_MUL: job.kind = KIND_MUL;
         FUNC_DIV: begin
            if (b == '0) begin
               job.result = a[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
               job.status = ST_DIV0;
            end else begin
               job.kind = KIND_DIV;
            end
         end
         FUNC_MIN: job.result = (a > b) ? b : a;
         FUNC_MAX: job.result = (a < b) ? b : a;
         FUNC_INC: begin
            job.result = sat_word(inc);
            job.status = is_ovf(inc) ? ST_SAT : ST_OK;
         end
         FUNC_DEC: begin
            job.result = sat_word(dec);
            job.status = is_ovf(dec) ? ST_SAT : ST_OK;
         end
         FUNC_INT: job.result = a >>> FRAC_BITS;
         default:  job.result = '0;
      endcase
   end
endmodule

// ----- hdl/fpa_queue.sv -----
// short request queue between front and back
`timescale 1ns / 1ps
module fpa_queue import fpa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  job_type wr_data,
   output logic    full,
   input  logic    rd_en,
   output logic    rd_valid,
   output job_type rd_data
);
`include "fixed_point_alu_top_assert.svh"
   job_type               mem_ff [0:Q_DEPTH-1];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_BITS:0]   cnt_ff, cnt_in;

   assign full     = cnt_ff == (Q_PTR_BITS+1)'(Q_DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data  = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (Q_PTR_BITS+1)'(wr_en) - (Q_PTR_BITS+1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `FPA_NEVER(a_q_overfill, clock, reset, cnt_ff > (Q_PTR_BITS+1)'(Q_DEPTH), "queue overfilled")
   `FPA_NEVER(a_q_read_empty, clock, reset, rd_en && !rd_valid, "read from empty queue")
   `FPA_NEVER(a_q_write_full, clock, reset, wr_en && full, "write to full queue")
endmodule

// ----- hdl/fpa_back.sv -----
// back end: multiplier and pipelined divider with final rounding and clamp
`timescale 1ns / 1ps
module fpa_back import fpa_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  job_type                     q_data,
   output logic                        q_pop,
   output logic                        empty,
   input  logic                        pop,
   output logic signed [PORT_BITS-1:0] rsp_result,
   output logic                        rsp_a_less,
   output logic                        rsp_a_equal,
   output logic                        rsp_a_greater,
   output logic [1:0]                  rsp_status
);
`include "fixed_point_alu_top_assert.svh"
   typedef struct packed {
      job_type              job;
      logic [PROD_BITS-1:0] prod;
      logic [NUM_BITS-1:0]  num;
      logic [WORD_BITS-1:0] den;
      logic [WORD_BITS-1:0] rem;
      logic [NUM_BITS-1:0]  quo;
   } stage_type;

   stage_type                   st_ff [0:DIV_STEPS];
   stage_type                   st_in [0:DIV_STEPS];
   logic [DIV_STEPS:0]          vld_ff;
   logic                        out_vld_ff;
   logic signed [WORD_BITS-1:0] res_ff, res_in;
   status_type                  sts_ff, sts_in;
   logic [2:0]                  flg_ff;
   logic                        en;
   logic [CLAMP_BITS-1:0]       mag;
   logic [CLAMP_BITS-1:0]       lim;
   logic [CLAMP_BITS-1:0]       negm;
   logic                        rnd;
   stage_type                   last;

   function automatic stage_type div_step(input stage_type s);
      stage_type          o;
      logic [WORD_BITS:0] shifted;
      logic [WORD_BITS:0] trial;
      logic               ge;
      o       = s;
      shifted = {s.rem, s.num[NUM_BITS-1]};
      trial   = shifted - {1'b0, s.den};
      ge      = shifted >= {1'b0, s.den};
      o.rem   = ge ? trial[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
      o.num   = s.num << 1;
      o.quo   = {s.quo[NUM_BITS-2:0], ge};
      return o;
   endfunction

   // whole pipeline moves when the output register is free or drained
   assign en    = !out_vld_ff || pop;
   assign q_pop = en && q_valid;

   // entry stage with product, then one quotient bit per stage
   always_comb begin
      st_in[0].job  = q_data;
      st_in[0].prod = PROD_BITS'(q_data.mag_a) * PROD_BITS'(q_data.mag_b);
      st_in[0].num  = NUM_BITS'(q_data.mag_a) << FRAC_BITS;
      st_in[0].den  = q_data.mag_b;
      st_in[0].rem  = '0;
      st_in[0].quo  = '0;
      for (int k = 1; k <= DIV_STEPS; k++) begin
         st_in[k] = div_step(st_ff[k-1]);
      end
   end

   // rounding and signed clamp of the last stage
   always_comb begin
      last = st_ff[DIV_STEPS];
      rnd  = {last.rem, 1'b0} >= {1'b0, last.den};
      case (last.job.kind)
         KIND_MUL: mag = (CLAMP_BITS'(last.prod) + MUL_HALF) >> FRAC_BITS;
         KIND_DIV: mag = CLAMP_BITS'(last.quo) + CLAMP_BITS'(rnd);
         default:  mag = '0;
      endcase
      lim  = last.job.neg ? LIM_NEG : LIM_POS;
      negm = ~mag + CLAMP_BITS'(1);
      if (last.job.kind == KIND_DIRECT) begin
         res_in = last.job.result;
         sts_in = last.job.status;
      end else if (mag > lim) begin
         res_in = last.job.neg ? WORD_MIN : WORD_MAX;
         sts_in = ST_SAT;
      end else begin
         res_in = last.job.neg ? negm[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
         sts_in = ST_OK;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[DIV_STEPS-1:0], q_valid};
         out_vld_ff <= vld_ff[DIV_STEPS];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= DIV_STEPS; k++) begin
            st_ff[k] <= st_in[k];
         end
         res_ff <= res_in;
         sts_ff <= sts_in;
         flg_ff <= {last.job.a_less, last.job.a_equal, last.job.a_greater};
      end
   end

   assign empty         = !out_vld_ff;
   assign rsp_result    = PORT_BITS'(res_ff);
   assign rsp_a_less    = flg_ff[2];
   assign rsp_a_equal   = flg_ff[1];
   assign rsp_a_greater = flg_ff[0];
   assign rsp_status    = sts_ff;

   `FPA_ASSERT(a_flags_onehot, clock, reset, out_vld_ff |-> $onehot(flg_ff), "compare flags not one-hot")
   `FPA_ASSERT(a_sat_at_limit, clock, reset, (out_vld_ff && sts_ff == ST_SAT) |-> (res_ff == WORD_MAX || res_ff == WORD_MIN), "saturated result off limit")
   `FPA_ASSERT(a_div0_at_limit, clock, reset, (out_vld_ff && sts_ff == ST_DIV0) |-> (res_ff == WORD_MAX || res_ff == WORD_MIN), "divide by zero result off limit")
endmodule

// ----- hdl/fixed_point_alu_top.sv -----
// Signed Q24.8 fixed-point alu (add, sub, mul, div, min, max, inc, dec, integer part)
// with saturation and compare flags. One request is taken every cycle unless the queue is
// full. Results come from a pipeline whose length is set by the divider,
// which resolves one quotient bit per pipeline stage. All operations share that
// pipeline so results leave in request order. A four-entry queue in front keeps
// taking requests, until it is full, while a result waits to be popped.
`timescale 1ns / 1ps
module fixed_point_alu_top import fpa_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [3:0]                  req_func,
   input  logic signed [PORT_BITS-1:0] req_operand_a,
   input  logic signed [PORT_BITS-1:0] req_operand_b,
   output logic                        empty,
   input  logic                        pop,
   output logic signed [PORT_BITS-1:0] rsp_result,
   output logic                        rsp_a_less,
   output logic                        rsp_a_equal,
   output logic                        rsp_a_greater,
   output logic [1:0]                  rsp_status
);
   job_type job;
   job_type q_data;
   logic    q_valid;
   logic    q_pop;

   // decode
   fpa_front u_front (
      .req_func      (req_func),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .job           (job)
   );

   // decoupling queue
   fpa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (push && !full),
      .wr_data  (job),
      .full     (full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_data)
   );

   // execute
   fpa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_data        (q_data),
      .q_pop         (q_pop),
      .empty         (empty),
      .pop           (pop),
      .rsp_result    (rsp_result),
      .rsp_a_less    (rsp_a_less),
      .rsp_a_equal   (rsp_a_equal),
      .rsp_a_greater (rsp_a_greater),
      .rsp_status    (rsp_status)
   );
endmodule

// ----- tb/fixed_point_alu_checker.sv -----
// checker for the fixed-point alu: predicts each request and compares results
`timescale 1ns / 1ps
module fixed_point_alu_checker import fpa_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic                        full,
   input  logic [3:0]                  req_func,
   input  logic signed [PORT_BITS-1:0] req_operand_a,
   input  logic signed [PORT_BITS-1:0] req_operand_b,
   input  logic                        empty,
   input  logic                        pop,
   input  logic signed [PORT_BITS-1:0] rsp_result,
   input  logic                        rsp_a_less,
   input  logic                        rsp_a_equal,
   input  logic                        rsp_a_greater,
   input  logic [1:0]                  rsp_status,
   output int                          fail_count,
   output int                          pending_count
);
   typedef struct packed {
      logic signed [31:0] result;
      logic               a_less;
      logic               a_equal;
      logic               a_greater;
      logic [1:0]         status;
   } alu_answer_type;

   alu_answer_type answer_queue[$];
   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   // clamp a 64-bit value to the word range
   function automatic longint clamp_word(input longint v, inout logic [1:0] st);
      if (v > SAT_HI) begin
         st = ST_SAT;
         return SAT_HI;
      end
      if (v < SAT_LO) begin
         st = ST_SAT;
         return SAT_LO;
      end
      return v;
   endfunction

   // apply a sign to a magnitude and clamp
   function automatic longint sign_clamp(input logic [63:0] mag, input logic neg,
                                         inout logic [1:0] st);
      logic [63:0] lim;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      if (mag > lim) begin
         st = ST_SAT;
         return neg ? SAT_LO : SAT_HI;
      end
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic alu_answer_type compute_answer(input logic [3:0] fn,
                                                     input logic signed [31:0] ra,
                                                     input logic signed [31:0] rb);
      alu_answer_type ans;
      longint a, b, r;
      logic [63:0] ma, mb, p, num, den;
      logic [1:0] st;
      a = ra;
      b = rb;
      st = ST_OK;
      ma = a < 0 ? 64'(-a) : 64'(a);
      mb = b < 0 ? 64'(-b) : 64'(b);
      case (fn)
         FUNC_ADD: r = clamp_word(a + b, st);
         FUNC_SUB: r = clamp_word(a - b, st);
         FUNC_MUL: begin
            p = ((ma * mb) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            r = sign_clamp(p, (a < 0) != (b < 0), st);
         end
         FUNC_DIV: begin
            if (b == 0) begin
               st = ST_DIV0;
               r = a < 0 ? SAT_LO : SAT_HI;
            end else begin
               num = ma << FRAC_BITS;
               den = mb;
               p = (2 * num + den) / (2 * den);
               r = sign_clamp(p, (a < 0) != (b < 0), st);
            end
         end
         FUNC_MIN: r = (a > b) ? b : a;
         FUNC_MAX: r = (a < b) ? b : a;
         FUNC_INC: r = clamp_word(a + 1, st);
         FUNC_DEC: r = clamp_word(a - 1, st);
         FUNC_INT: r = a >>> FRAC_BITS;
         default:  r = 0;
      endcase
      ans.result = r[31:0];
      ans.a_less = a < b;
      ans.a_equal = a == b;
      ans.a_greater = a > b;
      ans.status = st;
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;

   // track accepted requests and compare accepted results
   always @(posedge clock) begin
      alu_answer_type want;
      if (!reset) begin
         if (push && !full)
            answer_queue.push_back(compute_answer(req_func, req_operand_a, req_operand_b));
         if (pop && !empty) begin
            if (answer_queue.size() == 0) begin
               report_mismatch("unexpected result", rsp_result, 0);
            end else begin
               want = answer_queue.pop_front();
               if (rsp_result !== want.result)
                  report_mismatch("result", rsp_result, want.result);
               if (rsp_a_less !== want.a_less)
                  report_mismatch("a_less", rsp_a_less, want.a_less);
               if (rsp_a_equal !== want.a_equal)
                  report_mismatch("a_equal", rsp_a_equal, want.a_equal);
               if (rsp_a_greater !== want.a_greater)
                  report_mismatch("a_greater", rsp_a_greater, want.a_greater);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
            end
         end
      end
      pending_count = answer_queue.size();
   end
endmodule

// ----- tb/fixed_point_alu_top_test.sv -----
// top of the fixed-point alu testbench: stimulus, clock, reset and verdict
`timescale 1ns / 1ps
module fixed_point_alu_top_test;
   import fpa_pkg::*;

   localparam int RANDOM_COUNT = 600;
   localparam int HOLD_COUNT   = 80;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int QUIET_TAIL   = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic [3:0] req_func = FUNC_ADD;
   logic signed [PORT_BITS-1:0] req_operand_a = '0;
   logic signed [PORT_BITS-1:0] req_operand_b = '0;
   logic signed [PORT_BITS-1:0] rsp_result;
   logic rsp_a_less, rsp_a_equal, rsp_a_greater;
   logic [1:0] rsp_status;
   int fail_count, pending_count;
   int cycle_count = 0;
   bit calm_phase = 1'b0;
   bit hold_pop = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   fixed_point_alu_top i_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_func(req_func), .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .empty(empty), .pop(pop), .rsp_result(rsp_result), .rsp_a_less(rsp_a_less),
      .rsp_a_equal(rsp_a_equal), .rsp_a_greater(rsp_a_greater), .rsp_status(rsp_status)
   );

   fixed_point_alu_checker i_checker (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_func(req_func), .req_operand_a(req_operand_a), .req_operand_b(req_operand_b),
      .empty(empty), .pop(pop), .rsp_result(rsp_result), .rsp_a_less(rsp_a_less),
      .rsp_a_equal(rsp_a_equal), .rsp_a_greater(rsp_a_greater), .rsp_status(rsp_status),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side: random pop bursts, long hold on request
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_pop || (!calm_phase && $urandom_range(0, 3) == 0)) begin
            pop <= 1'b0;
            n = hold_pop ? 1 : $urandom_range(1, 12);
            repeat (n - 1) @(negedge clock);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   // offer one request and wait until it is taken
   task automatic send_request(input logic [3:0] fn, input logic [31:0] a,
                               input logic [31:0] b);
      req_func <= fn;
      req_operand_a <= a;
      req_operand_b <= b;
      push <= 1'b1;
      do @(posedge clock); while (full);
      @(negedge clock);
      if (!calm_phase && $urandom_range(0, 4) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   // operand with bias toward edge values and small fixed-point numbers
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return 32'h7fffffff - $urandom_range(0, 2);
         1: return 32'h80000000 + $urandom_range(0, 2);
         2: return 32'($signed($urandom_range(0, 8)) - 4);
         3: return 32'($signed($urandom_range(0, 4096)) - 2048);
         4: return 32'($signed($urandom_range(0, 32'h1000000)) - 32'sh800000);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      logic [31:0] a;
      int fn;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: edges, every operation, special cases
      send_request(FUNC_ADD, 32'h7fffffff, 32'h1);
      send_request(FUNC_ADD, 32'h80000000, 32'hffffffff);
      send_request(FUNC_SUB, 32'h80000000, 32'h1);
      send_request(FUNC_SUB, 32'h7fffffff, 32'hffffffff);
      send_request(FUNC_MUL, 32'h00000180, 32'hfffffe80);
      send_request(FUNC_MUL, 32'h7fffffff, 32'h7fffffff);
      send_request(FUNC_MUL, 32'h80000000, 32'h80000000);
      send_request(FUNC_MUL, 32'h00000001, 32'h00000080);
      send_request(FUNC_MUL, 32'hffffffff, 32'h00000080);
      send_request(FUNC_DIV, 32'h00000100, 32'h00000000);
      send_request(FUNC_DIV, 32'hffffff00, 32'h00000000);
      send_request(FUNC_DIV, 32'h80000000, 32'h00000100);
      send_request(FUNC_DIV, 32'h80000000, 32'hffffff00);
      send_request(FUNC_DIV, 32'h00000001, 32'h00000200);
      send_request(FUNC_DIV, 32'h7fffffff, 32'h00000001);
      send_request(FUNC_MIN, 32'h00000005, 32'h00000005);
      send_request(FUNC_MAX, 32'h80000000, 32'h7fffffff);
      send_request(FUNC_INC, 32'h7fffffff, 32'h0);
      send_request(FUNC_DEC, 32'h80000000, 32'h0);
      send_request(FUNC_INT, 32'hffffff01, 32'h0);
      send_request(FUNC_INT, 32'h80000000, 32'h7fffffff);
      send_request(4'd9, 32'h1, 32'h2);
      send_request(4'd15, 32'hffffffff, 32'hffffffff);

      // receiver holds off long while requests keep coming, so input stalls
      hold_pop = 1'b1;
      fork
         begin
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_pop = 1'b0;
         end
         repeat (HOLD_COUNT)
            send_request(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
      join

      // random part
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         if (i == RANDOM_COUNT / 2) begin
            // sender pauses until everything has drained
            push <= 1'b0;
            while (pending_count != 0) @(negedge clock);
         end
         if (i == RANDOM_COUNT - 120) calm_phase = 1'b1;
         fn = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
         a = pick_operand();
         send_request(4'(fn), a, ($urandom_range(0, 5) == 0) ? a : pick_operand());
      end
      push <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (QUIET_TAIL) @(negedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
